// ===== hw/rtl/rdlw_pkg.sv =====
// Shared types and constants for the radial distortion LUT warp unit.
// No dependencies; imported by every module of the block.
package rdlw_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS_TO_INDEX = 2'd0;
  localparam logic [1:0] REG_INV_EDGE_TAN_X  = 2'd1;
  localparam logic [1:0] REG_INV_EDGE_TAN_Y  = 2'd2;

  localparam logic [23:0] RADIUS_TO_INDEX_RST = 24'd4096;
  localparam logic [15:0] INV_EDGE_TAN_RST    = 16'd4096;

  // item operations and channel codes
  localparam logic OP_WARP  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_NONE  = 2'd3;

  localparam int S_W = 35;  // interpolated radius, signed integer

  // one beat as it travels the front of the pipeline
  typedef struct packed {
    logic               vld;
    logic               op;
    logic [1:0]         ch;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic [9:0]         eidx;
    logic [15:0]        eval;
  } rdlw_side_t;

  // beat handed from the table stages to the axis scaling
  typedef struct packed {
    logic                  res;
    logic signed [15:0]    ux;
    logic signed [15:0]    vy;
    logic signed [S_W-1:0] s;
  } rdlw_sv_t;

endpackage

// ===== hw/rtl/rdlw_isqrt.sv =====
// Pipelined integer square root of u*u + v*v, one result bit per stage.
// Depends on rdlw_pkg.
module rdlw_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  rdlw_pkg::rdlw_side_t side_i,
  output rdlw_pkg::rdlw_side_t side_o,
  output logic [15:0]         root_o
);
  import rdlw_pkg::*;

  localparam int STEPS = 16;

  rdlw_side_t         sq_side_r;
  logic signed [31:0] usq_r;
  logic signed [31:0] vsq_r;

  rdlw_side_t  side_r [STEPS+1];
  logic [31:0] n_r    [STEPS+1];
  logic [19:0] rem_r  [STEPS+1];
  logic [15:0] root_r [STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_side_r.vld <= 1'b0;
      side_r[0].vld <= 1'b0;
    end else if (en) begin
      sq_side_r <= side_i;
      usq_r     <= side_i.u * side_i.u;
      vsq_r     <= side_i.v * side_i.v;
      side_r[0] <= sq_side_r;
      n_r[0]    <= $unsigned(usq_r) + $unsigned(vsq_r);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [19:0] rem_sh;
    logic [19:0] trial;
    logic        ge;

    always_comb begin
      rem_sh = {rem_r[k-1][17:0], n_r[k-1][31:30]};
      trial  = {2'b00, root_r[k-1], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].vld <= 1'b0;
      end else if (en) begin
        side_r[k] <= side_r[k-1];
        n_r[k]    <= {n_r[k-1][29:0], 2'b00};
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {root_r[k-1][14:0], ge};
      end
    end
  end

  assign side_o = side_r[STEPS];
  assign root_o = root_r[STEPS];

endmodule

// ===== hw/rtl/rdlw_div.sv =====
// Pipelined restoring divider: unit direction u*2^14/r and v*2^14/r,
// truncated toward zero, one quotient bit per stage. Depends on rdlw_pkg.
module rdlw_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  rdlw_pkg::rdlw_side_t side_i,
  input  logic [15:0]         r_i,
  output rdlw_pkg::rdlw_side_t side_o,
  output logic [15:0]         r_o,
  output logic signed [15:0]  ux_o,
  output logic signed [15:0]  vy_o
);
  import rdlw_pkg::*;

  localparam int QB = 15;  // |u| <= r, so the quotient is at most 2^14

  rdlw_side_t  side_r [QB+1];
  logic [15:0] d_r    [QB+1];
  logic [29:0] rem_r  [QB+1][2];
  logic [14:0] q_r    [QB+1][2];
  logic        neg_r  [QB+1][2];

  logic [15:0] mag_u;
  logic [15:0] mag_v;

  always_comb begin
    mag_u = side_i.u[15] ? (16'd0 - side_i.u) : side_i.u;
    mag_v = side_i.v[15] ? (16'd0 - side_i.v) : side_i.v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r[0].vld <= 1'b0;
    end else if (en) begin
      side_r[0]   <= side_i;
      d_r[0]      <= r_i;
      rem_r[0][0] <= {mag_u, 14'd0};
      rem_r[0][1] <= {mag_v, 14'd0};
      q_r[0][0]   <= '0;
      q_r[0][1]   <= '0;
      neg_r[0][0] <= side_i.u[15];
      neg_r[0][1] <= side_i.v[15];
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [30:0] dsh;
    logic [30:0] rem_ext [2];
    logic        ge      [2];

    always_comb begin
      dsh = {15'd0, d_r[k-1]} << (QB - k);
      for (int a = 0; a < 2; a++) begin
        rem_ext[a] = {1'b0, rem_r[k-1][a]};
        ge[a]      = (rem_ext[a] >= dsh);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].vld <= 1'b0;
      end else if (en) begin
        side_r[k] <= side_r[k-1];
        d_r[k]    <= d_r[k-1];
        for (int a = 0; a < 2; a++) begin
          rem_r[k][a] <= ge[a] ? 30'(rem_ext[a] - dsh) : rem_r[k-1][a];
          q_r[k][a]   <= {q_r[k-1][a][13:0], ge[a]};
          neg_r[k][a] <= neg_r[k-1][a];
        end
      end
    end
  end

  // zero radius means u = v = 0; the raw quotient would be all ones
  logic signed [15:0] res [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (d_r[QB] == 16'd0) begin
        res[a] = '0;
      end else if (neg_r[QB][a]) begin
        res[a] = -$signed({1'b0, q_r[QB][a]});
      end else begin
        res[a] = $signed({1'b0, q_r[QB][a]});
      end
    end
  end

  rdlw_side_t         oside_r;
  logic [15:0]        or_r;
  logic signed [15:0] oux_r;
  logic signed [15:0] ovy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oside_r.vld <= 1'b0;
    end else if (en) begin
      oside_r <= side_r[QB];
      or_r    <= d_r[QB];
      oux_r   <= res[0];
      ovy_r   <= res[1];
    end
  end

  assign side_o = oside_r;
  assign r_o    = or_r;
  assign ux_o   = oux_r;
  assign vy_o   = ovy_r;

endmodule

// ===== hw/rtl/rdlw_lut.sv =====
// Radius to table index, per-channel radial table memories and linear
// interpolation. Depends on rdlw_pkg.
module rdlw_lut #(
  parameter int TABLE_DEPTH = rdlw_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [23:0]         radius_to_index,
  input  rdlw_pkg::rdlw_side_t side_i,
  input  logic [15:0]         r_i,
  input  logic signed [15:0]  ux_i,
  input  logic signed [15:0]  vy_i,
  output rdlw_pkg::rdlw_sv_t  sv_o
);
  import rdlw_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [15:0] IDX_MAX = 16'(TABLE_DEPTH - 2);

  typedef struct packed {
    logic               vld;
    logic               op;
    logic [1:0]         ch;
    logic signed [15:0] ux;
    logic signed [15:0] vy;
    logic [15:0]        r;
  } warp_t;

  logic [15:0] red_mem   [TABLE_DEPTH];
  logic [15:0] green_mem [TABLE_DEPTH];
  logic [15:0] blue_mem  [TABLE_DEPTH];

  // L1: index product
  warp_t       w1_r;
  logic [9:0]  eidx1_r;
  logic [15:0] eval1_r;
  logic [39:0] prod1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r.vld <= 1'b0;
    end else if (en) begin
      w1_r    <= '{vld: side_i.vld, op: side_i.op, ch: side_i.ch,
                   ux: ux_i, vy: vy_i, r: r_i};
      eidx1_r <= side_i.eidx;
      eval1_r <= side_i.eval;
      prod1_r <= r_i * radius_to_index;
    end
  end

  // L2: clamp, fraction, table access
  logic [15:0]   idx16;
  logic [27:0]   t_c;
  logic [IW-1:0] ra;
  logic [IW-1:0] rb;
  logic [IW-1:0] wa;
  logic          wr_ok;

  always_comb begin
    idx16 = (prod1_r[39:24] > IDX_MAX) ? IDX_MAX : prod1_r[39:24];
    t_c   = prod1_r[39:12] - {idx16, 12'd0};
    ra    = IW'(idx16);
    rb    = IW'(idx16 + 16'd1);
    wa    = IW'(eidx1_r);
    wr_ok = en && w1_r.vld && (w1_r.op == OP_WRITE) && (int'(eidx1_r) < TABLE_DEPTH);
  end

  warp_t       w2_r;
  logic [27:0] t2_r;
  logic [15:0] red_a_r, red_b_r, green_a_r, green_b_r, blue_a_r, blue_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w2_r.vld <= 1'b0;
    end else if (en) begin
      w2_r <= w1_r;
      t2_r <= t_c;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      case (w1_r.ch)
        CH_RED:   red_mem[wa]   <= eval1_r;
        CH_GREEN: green_mem[wa] <= eval1_r;
        CH_BLUE:  blue_mem[wa]  <= eval1_r;
        default:  ;
      endcase
    end
    if (en) begin
      red_a_r   <= red_mem[ra];
      red_b_r   <= red_mem[rb];
      green_a_r <= green_mem[ra];
      green_b_r <= green_mem[rb];
      blue_a_r  <= blue_mem[ra];
      blue_b_r  <= blue_mem[rb];
    end
  end

  // L3: channel select and slope
  logic [15:0] a_c;
  logic [15:0] b_c;
  always_comb begin
    case (w2_r.ch)
      CH_RED:   begin a_c = red_a_r;   b_c = red_b_r;   end
      CH_GREEN: begin a_c = green_a_r; b_c = green_b_r; end
      CH_BLUE:  begin a_c = blue_a_r;  b_c = blue_b_r;  end
      default:  begin a_c = '0;        b_c = '0;        end
    endcase
  end

  warp_t              w3_r;
  logic [15:0]        a3_r;
  logic signed [16:0] diff3_r;
  logic [27:0]        t3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w3_r.vld <= 1'b0;
    end else if (en) begin
      w3_r    <= w2_r;
      a3_r    <= a_c;
      diff3_r <= $signed({1'b0, b_c}) - $signed({1'b0, a_c});
      t3_r    <= t2_r;
    end
  end

  // L4: fraction times slope
  warp_t              w4_r;
  logic [15:0]        a4_r;
  logic signed [45:0] p4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w4_r.vld <= 1'b0;
    end else if (en) begin
      w4_r <= w3_r;
      a4_r <= a3_r;
      p4_r <= $signed({1'b0, t3_r}) * diff3_r;
    end
  end

  // L5: interpolated radius; no table on channel three
  logic signed [S_W-1:0] s_c;
  always_comb begin
    if (w4_r.ch == CH_NONE) begin
      s_c = $signed(S_W'(w4_r.r));
    end else begin
      s_c = S_W'($signed({1'b0, a4_r})) + S_W'(p4_r >>> 12);
    end
  end

  rdlw_sv_t sv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r.res <= 1'b0;
    end else if (en) begin
      sv_r.res <= w4_r.vld && (w4_r.op == OP_WARP);
      sv_r.ux  <= w4_r.ux;
      sv_r.vy  <= w4_r.vy;
      sv_r.s   <= s_c;
    end
  end

  assign sv_o = sv_r;

endmodule

// ===== hw/rtl/rdlw_scale.sv =====
// Direction times radius, per-axis edge tangent scaling, saturation and
// the output register. Depends on rdlw_pkg.
module rdlw_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [15:0]        inv_edge_tan_x,
  input  logic [15:0]        inv_edge_tan_y,
  input  rdlw_pkg::rdlw_sv_t sv_i,
  output logic               out_valid,
  output logic signed [15:0] out_warped_x,
  output logic signed [15:0] out_warped_y,
  output logic               out_saturated
);
  import rdlw_pkg::*;

  localparam int PW = S_W + 16;
  localparam int AW = PW - 14;
  localparam int MW = AW + 17;
  localparam int XW = MW - 12;

  logic                res1_r;
  logic signed [PW-1:0] px1_r, py1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res1_r <= 1'b0;
    end else if (en) begin
      res1_r <= sv_i.res;
      px1_r  <= sv_i.ux * sv_i.s;
      py1_r  <= sv_i.vy * sv_i.s;
    end
  end

  logic signed [AW-1:0] ax_c, ay_c;
  always_comb begin
    ax_c = AW'(px1_r >>> 14);
    ay_c = AW'(py1_r >>> 14);
  end

  logic                res2_r;
  logic signed [MW-1:0] mx2_r, my2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res2_r <= 1'b0;
    end else if (en) begin
      res2_r <= res1_r;
      mx2_r  <= ax_c * $signed({1'b0, inv_edge_tan_x});
      my2_r  <= ay_c * $signed({1'b0, inv_edge_tan_y});
    end
  end

  logic signed [XW-1:0] xs_c, ys_c;
  logic signed [15:0]   xo_c, yo_c;
  logic                 sat_c;

  always_comb begin
    xs_c  = XW'(mx2_r >>> 12);
    ys_c  = XW'(my2_r >>> 12);
    sat_c = 1'b0;
    if (xs_c > XW'(32767)) begin
      xo_c = 16'sh7fff; sat_c = 1'b1;
    end else if (xs_c < -XW'(32768)) begin
      xo_c = -16'sh8000; sat_c = 1'b1;
    end else begin
      xo_c = 16'(xs_c);
    end
    if (ys_c > XW'(32767)) begin
      yo_c = 16'sh7fff; sat_c = 1'b1;
    end else if (ys_c < -XW'(32768)) begin
      yo_c = -16'sh8000; sat_c = 1'b1;
    end else begin
      yo_c = 16'(ys_c);
    end
  end

  logic               ovld_r;
  logic signed [15:0] ox_r, oy_r;
  logic               osat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= res2_r;
      ox_r   <= xo_c;
      oy_r   <= yo_c;
      osat_r <= sat_c;
    end
  end

  assign out_valid     = ovld_r;
  assign out_warped_x  = ox_r;
  assign out_warped_y  = oy_r;
  assign out_saturated = osat_r;

endmodule

// ===== hw/rtl/radial_distortion_lut_warp_unit.sv =====
// Radial lens warp: one beat per clock while the output is not stalled,
// through squares and their sum, a 16-stage square root, a divider for the
// unit direction with a load register, 15 quotient stages and an output
// register, five table/interpolation stages, two scaling stages and the
// output register. Warp and table-write beats share one in-order pipeline,
// so a write is seen by every later warp. The whole pipeline advances while
// the output register is empty or being taken; in_ready follows that. Table
// entries are undefined until written. Configuration is taken any cycle.
module radial_distortion_lut_warp_unit #(
  parameter int TABLE_DEPTH = rdlw_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic signed [15:0] in_coord_u,
  input  logic signed [15:0] in_coord_v,
  input  logic [1:0]         in_channel,
  input  logic [9:0]         in_entry_index,
  input  logic [15:0]        in_entry_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_warped_x,
  output logic signed [15:0] out_warped_y,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import rdlw_pkg::*;

  logic [23:0] radius_to_index_r;
  logic [15:0] inv_edge_tan_x_r;
  logic [15:0] inv_edge_tan_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_to_index_r <= RADIUS_TO_INDEX_RST;
      inv_edge_tan_x_r  <= INV_EDGE_TAN_RST;
      inv_edge_tan_y_r  <= INV_EDGE_TAN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIUS_TO_INDEX: radius_to_index_r <= cfg_data;
        REG_INV_EDGE_TAN_X:  inv_edge_tan_x_r  <= cfg_data[15:0];
        REG_INV_EDGE_TAN_Y:  inv_edge_tan_y_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rdlw_side_t in_side;
  assign in_side = '{vld: in_valid, op: in_op, ch: in_channel, u: in_coord_u,
                     v: in_coord_v, eidx: in_entry_index, eval: in_entry_value};

  rdlw_side_t sq_side;
  logic [15:0] root;

  rdlw_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .side_i(in_side), .side_o(sq_side), .root_o(root)
  );

  rdlw_side_t dv_side;
  logic [15:0] dv_r;
  logic signed [15:0] ux, vy;

  rdlw_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .side_i(sq_side), .r_i(root),
    .side_o(dv_side), .r_o(dv_r), .ux_o(ux), .vy_o(vy)
  );

  rdlw_sv_t sv;

  rdlw_lut #(.TABLE_DEPTH(TABLE_DEPTH)) u_lut (
    .clk(clk), .rst_n(rst_n), .en(en),
    .radius_to_index(radius_to_index_r),
    .side_i(dv_side), .r_i(dv_r), .ux_i(ux), .vy_i(vy),
    .sv_o(sv)
  );

  rdlw_scale u_scale (
    .clk(clk), .rst_n(rst_n), .en(en),
    .inv_edge_tan_x(inv_edge_tan_x_r), .inv_edge_tan_y(inv_edge_tan_y_r),
    .sv_i(sv),
    .out_valid(out_valid), .out_warped_x(out_warped_x),
    .out_warped_y(out_warped_y), .out_saturated(out_saturated)
  );

`ifndef SYNTHESIS
  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_warped_x == 16'sh7fff) || (out_warped_x == -16'sh8000) ||
      (out_warped_y == 16'sh7fff) || (out_warped_y == -16'sh8000))
    else $error("saturated flag without a clipped coordinate");

  a_no_beat_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready ##1
      (out_valid && $stable(out_warped_x) && $stable(out_warped_y) &&
       $stable(out_saturated)))
    else $error("pipeline advanced while result stalled");
`endif

endmodule

// ===== tb/tb_radial_distortion_lut_warp_unit.sv =====
// Self-checking testbench for radial_distortion_lut_warp_unit.
// Needs rdlw_pkg and the block; a scoreboard class predicts every warp beat.
module tb_radial_distortion_lut_warp_unit;
  import rdlw_pkg::*;

  typedef struct {
    logic               op;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic [1:0]         ch;
    logic [9:0]         eidx;
    logic [15:0]        eval;
  } pix_beat_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               sat;
  } warp_coord_t;

  class warp_scoreboard;
    logic [15:0]  lut [3][1024];
    bit           filled [3][1024];
    logic [23:0]  r2i;
    logic [15:0]  tan_x;
    logic [15:0]  tan_y;
    warp_coord_t  expected_coords[$];
    int           errors;

    function new();
      r2i   = RADIUS_TO_INDEX_RST;
      tan_x = INV_EDGE_TAN_RST;
      tan_y = INV_EDGE_TAN_RST;
      errors = 0;
      foreach (filled[c, i]) filled[c][i] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        REG_RADIUS_TO_INDEX: r2i = data;
        REG_INV_EDGE_TAN_X:  tan_x = data[15:0];
        REG_INV_EDGE_TAN_Y:  tan_y = data[15:0];
        default: ;
      endcase
    endfunction

    function longint radius_of(logic signed [15:0] u, logic signed [15:0] v);
      longint unsigned n, r, b;
      longint su, sv;
      su = u;
      sv = v;
      n = su * su + sv * sv;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    // lower table entry a warp at (u, v) reads under the current setting
    function int slot_of(logic signed [15:0] u, logic signed [15:0] v);
      longint unsigned prod;
      prod = longint'(radius_of(u, v)) * longint'(r2i);
      prod = prod >> 24;
      return (prod > 1022) ? 1022 : int'(prod);
    endfunction

    function bit slot_ready(logic [1:0] ch, int k);
      return filled[ch][k] && filled[ch][k + 1];
    endfunction

    function logic signed [15:0] scale_axis(longint unit, longint s, logic [15:0] inv,
                                            inout logic sat);
      longint a, x;
      a = (unit * s) >>> 14;
      x = (a * longint'(inv)) >>> 12;
      if (x > 32767) begin
        x = 32767;
        sat = 1;
      end else if (x < -32768) begin
        x = -32768;
        sat = 1;
      end
      return x[15:0];
    endfunction

    function void note_beat(pix_beat_t b);
      longint r, ux, vy, s, t, lo, hi, su, sv;
      int k;
      warp_coord_t e;
      if (b.op == OP_WRITE) begin
        if (b.ch != CH_NONE) begin
          lut[b.ch][b.eidx]    = b.eval;
          filled[b.ch][b.eidx] = 1;
        end
        return;
      end
      su = b.u;
      sv = b.v;
      r = radius_of(b.u, b.v);
      ux = 0;
      vy = 0;
      if (r != 0) begin
        ux = (su * 16384) / r;
        vy = (sv * 16384) / r;
      end
      if (b.ch != CH_NONE) begin
        k  = slot_of(b.u, b.v);
        t  = longint'((longint'(r) * longint'(r2i)) >> 12) - longint'(k) * 4096;
        lo = lut[b.ch][k];
        hi = lut[b.ch][k + 1];
        s  = lo + ((t * (hi - lo)) >>> 12);
      end else begin
        s = r;
      end
      e.sat = 0;
      e.x = scale_axis(ux, s, tan_x, e.sat);
      e.y = scale_axis(vy, s, tan_y, e.sat);
      expected_coords = {expected_coords, e};
    endfunction

    function void check_result(logic signed [15:0] x, logic signed [15:0] y, logic sat);
      warp_coord_t e;
      if (expected_coords.size() == 0) begin
        $error("result beat with nothing expected: x=%0d y=%0d", x, y);
        errors++;
        return;
      end
      e = expected_coords.pop_front();
      if (x !== e.x) begin
        $error("warped_x: expected %0d, got %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("warped_y: expected %0d, got %0d", e.y, y);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated: expected %0d, got %0d", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_op;
  logic signed [15:0] in_coord_u;
  logic signed [15:0] in_coord_v;
  logic [1:0]         in_channel;
  logic [9:0]         in_entry_index;
  logic [15:0]        in_entry_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_warped_x;
  logic signed [15:0] out_warped_y;
  logic               out_saturated;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [23:0]        cfg_data;

  warp_scoreboard sb = new();
  bit             burst_mode;

  radial_distortion_lut_warp_unit dut (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #4000000;
    $display("radial_distortion_lut_warp_unit test failed");
    $finish;
  end

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (burst_mode || p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      n = gap_len();
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_warped_x, out_warped_y, out_saturated);

  // called at a falling edge; returns at a falling edge with in_valid possibly still high
  task automatic send_beat(pix_beat_t b);
    int n;
    in_valid       = 1'b1;
    in_op          = b.op;
    in_coord_u     = b.u;
    in_coord_v     = b.v;
    in_channel     = b.ch;
    in_entry_index = b.eidx;
    in_entry_value = b.eval;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_beat(b);
    @(negedge clk);
    n = gap_len();
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_entry(logic [1:0] ch, logic [9:0] idx, logic [15:0] val);
    pix_beat_t b;
    b.op = OP_WRITE;
    b.u = 16'($urandom);
    b.v = 16'($urandom);
    b.ch = ch;
    b.eidx = idx;
    b.eval = val;
    send_beat(b);
  endtask

  // fills the two entries a warp will read before sending it
  task automatic warp(logic signed [15:0] u, logic signed [15:0] v, logic [1:0] ch);
    pix_beat_t b;
    int k;
    if (ch != CH_NONE) begin
      k = sb.slot_of(u, v);
      if (!sb.filled[ch][k]) write_entry(ch, 10'(k), 16'($urandom));
      if (!sb.filled[ch][k + 1]) write_entry(ch, 10'(k + 1), 16'($urandom));
    end
    b.op = OP_WARP;
    b.u = u;
    b.v = v;
    b.ch = ch;
    b.eidx = 10'($urandom);
    b.eval = 16'($urandom);
    send_beat(b);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_coords.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sd0;
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: return 16'(int'($urandom_range(0, 1200)) - 600);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [23:0] r2i_set [6];
    logic [15:0] tx_set [6];
    logic [15:0] ty_set [6];
    logic [1:0]  ch;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_WARP;
    in_coord_u = '0;
    in_coord_v = '0;
    in_channel = CH_RED;
    in_entry_index = '0;
    in_entry_value = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_RADIUS_TO_INDEX;
    cfg_data = '0;
    burst_mode = 0;
    r2i_set = '{24'd4096, 24'd0, 24'hffffff, 24'd1 << 20,
                24'($urandom_range(0, 1 << 16)), 24'd262144};
    tx_set  = '{16'd4096, 16'hffff, 16'd0, 16'($urandom), 16'($urandom), 16'd4096};
    ty_set  = '{16'd4096, 16'd0, 16'hffff, 16'($urandom), 16'($urandom), 16'd4096};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: table extremes, all channels, ignored writes, corner radii
    write_entry(CH_RED, 10'd0, 16'd0);
    write_entry(CH_RED, 10'd1, 16'hffff);
    write_entry(CH_RED, 10'd1023, 16'hffff);
    write_entry(CH_GREEN, 10'd0, 16'd4096);
    write_entry(CH_BLUE, 10'd0, 16'h8000);
    write_entry(CH_NONE, 10'd5, 16'h1234);
    warp(16'sd0, 16'sd0, CH_RED);
    warp(16'sh7fff, 16'sh7fff, CH_RED);
    warp(16'sh8000, 16'sh8000, CH_GREEN);
    warp(16'sh7fff, 16'sh8000, CH_BLUE);
    warp(16'sh8000, 16'sd0, CH_NONE);
    warp(16'sd0, 16'sh7fff, CH_NONE);
    warp(16'sd4096, 16'sd0, CH_RED);
    warp(16'sd1, 16'sd1, CH_GREEN);
    warp(-16'sd1, 16'sd0, CH_BLUE);
    warp(16'sd2896, -16'sd2896, CH_RED);

    for (int p = 0; p < 6; p++) begin
      // config changes only with the pipeline empty
      drain();
      if (p != 0) begin
        write_reg(REG_RADIUS_TO_INDEX, r2i_set[p]);
        write_reg(REG_INV_EDGE_TAN_X, {8'd0, tx_set[p]});
        write_reg(REG_INV_EDGE_TAN_Y, {8'd0, ty_set[p]});
      end
      for (int i = 0; i < 130; i++) begin
        if (i % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        ch = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0)
          write_entry(ch, 10'($urandom), 16'($urandom));
        else
          warp(rand_coord(), rand_coord(), ch);
      end
    end
    burst_mode = 0;
    drain();
    if (sb.errors == 0 && sb.expected_coords.size() == 0)
      $display("radial_distortion_lut_warp_unit test passed");
    else
      $display("radial_distortion_lut_warp_unit test failed");
    $finish;
  end
endmodule
